FILE: rtl/firadc_pkg.sv
// ----------------------------------------------------------------------------
// firadc_pkg
// Shared widths, item types, sequencer states and the low-pass coefficient
// table for the ADC sample FIR filter.
// ----------------------------------------------------------------------------
package firadc_pkg;

   localparam int MAX_TAPS   = 64;
   localparam int TAP_W      = $clog2(MAX_TAPS);
   localparam int TAPS_W     = 7;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 18;
   localparam int RESULT_W   = 26;
   localparam int TABLE_LEN  = 41;
   localparam int PROD_W     = SAMPLE_W + 1 + COEF_W;
   localparam int ACC_W      = PROD_W + TAP_W;

   localparam logic [TAPS_W-1:0] TAPS_RESET = 7'd41;

   localparam logic signed [COEF_W-1:0] LP_TABLE [0:TABLE_LEN-1] = '{
       18'sd770,  18'sd1012, 18'sd1268, 18'sd1534, 18'sd1810, 18'sd2091,
      18'sd2375, 18'sd2658, 18'sd2938, 18'sd3211, 18'sd3474, 18'sd3724,
      18'sd3956, 18'sd4170, 18'sd4360, 18'sd4526, 18'sd4665, 18'sd4775,
      18'sd4855, 18'sd4903, 18'sd4919, 18'sd4903, 18'sd4855, 18'sd4775,
      18'sd4665, 18'sd4526, 18'sd4360, 18'sd4170, 18'sd3956, 18'sd3724,
      18'sd3474, 18'sd3211, 18'sd2938, 18'sd2658, 18'sd2375, 18'sd2091,
      18'sd1810, 18'sd1534, 18'sd1268, 18'sd1012,  18'sd770
   };

   typedef enum logic [1:0] {
      MAC_IDLE,
      MAC_RUN,
      MAC_DRAIN
   } mac_state_type;

   typedef struct packed {
      logic                vld;
      logic [SAMPLE_W-1:0] sample;
   } smp_item_type;

   typedef struct packed {
      logic                       vld;
      logic signed [RESULT_W-1:0] filtered_value;
   } res_item_type;

   function automatic logic signed [COEF_W-1:0] coef_rom(input logic [TAP_W-1:0] idx);
      logic signed [COEF_W-1:0] c;
      if (int'(idx) < TABLE_LEN) begin
         c = LP_TABLE[idx];
      end else begin
         c = '0;
      end
      return c;
   endfunction

endpackage

FILE: rtl/firadc_front.sv
// ----------------------------------------------------------------------------
// firadc_front
// Input side: accepts sample items into a four-entry queue that the MAC
// engine drains at its own pace.
// ----------------------------------------------------------------------------
module firadc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [firadc_pkg::SAMPLE_W-1:0]   req_sample,
   output firadc_pkg::smp_item_type          smp_item,
   input  logic                              smp_pop
);
   import firadc_pkg::*;

   logic [SAMPLE_W-1:0] slot_ff [0:3];
   logic [1:0]          wr_ptr_ff;
   logic [1:0]          rd_ptr_ff;
   logic [2:0]          count_ff;
   logic [2:0]          count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == 3'd4);
   assign do_push = push && !full;
   assign do_pop  = smp_pop && (count_ff != 3'd0);

   assign smp_item.vld    = (count_ff != 3'd0);
   assign smp_item.sample = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 3'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
      end
   end

endmodule

FILE: rtl/firadc_mac.sv
// ----------------------------------------------------------------------------
// firadc_mac
// Back end: circular delay line, tap count register and one shared
// multiply-accumulate that walks the taps newest first, then rounds and
// saturates the sum.
// ----------------------------------------------------------------------------
module firadc_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [firadc_pkg::TAPS_W-1:0]     csr_wr_data,
   input  firadc_pkg::smp_item_type          smp_item,
   output logic                              smp_pop,
   input  logic                              res_room,
   output firadc_pkg::res_item_type          res_item
);
   import firadc_pkg::*;

   localparam logic signed [ACC_W:0] OUT_MAX = (ACC_W+1)'(33554431);
   localparam logic signed [ACC_W:0] OUT_MIN = -(ACC_W+1)'(33554432);

   mac_state_type              state_ff;
   mac_state_type              state_in;
   logic [TAPS_W-1:0]          num_taps_ff;
   logic [TAPS_W-1:0]          taps_m;
   logic [TAP_W-1:0]           last_tap;
   logic [TAP_W-1:0]           head_ff;
   logic [TAP_W-1:0]           head_eff;
   logic [TAP_W-1:0]           head_next;
   logic [TAP_W-1:0]           k_ff;
   logic [TAP_W-1:0]           k_in;
   logic [TAP_W-1:0]           idx_ff;
   logic [TAP_W-1:0]           idx_in;
   logic                       start;
   logic                       issue;
   logic                       done;

   logic [SAMPLE_W-1:0]        delay_mem [0:MAX_TAPS-1];
   logic [MAX_TAPS-1:0]        line_vld_ff;
   logic [SAMPLE_W-1:0]        rd_data_ff;
   logic                       rd_ok_ff;
   logic signed [COEF_W-1:0]   coef_ff;
   logic                       s1_vld_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       s2_vld_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [SAMPLE_W:0]   mul_a;
   logic signed [ACC_W:0]      rnd_sum;
   logic signed [ACC_W:0]      rnd_shift;
   logic signed [RESULT_W-1:0] sat_value;

   always_comb begin
      if (num_taps_ff == '0) begin
         taps_m = TAPS_W'(1);
      end else if (num_taps_ff > TAPS_W'(MAX_TAPS)) begin
         taps_m = TAPS_W'(MAX_TAPS);
      end else begin
         taps_m = num_taps_ff;
      end
   end

   assign last_tap  = TAP_W'(taps_m - TAPS_W'(1));
   assign head_eff  = ({1'b0, head_ff} >= taps_m) ? '0 : head_ff;
   assign head_next = (head_eff == last_tap) ? '0 : head_eff + TAP_W'(1);

   assign start   = (state_ff == MAC_IDLE) && smp_item.vld && res_room;
   assign issue   = (state_ff == MAC_RUN);
   assign done    = (state_ff == MAC_DRAIN) && !s1_vld_ff && !s2_vld_ff;
   assign smp_pop = start;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         MAC_IDLE: begin
            if (start) begin
               state_in = MAC_RUN;
               k_in     = head_eff;
               idx_in   = '0;
            end
         end
         MAC_RUN: begin
            k_in   = (k_ff == '0) ? last_tap : k_ff - TAP_W'(1);
            idx_in = idx_ff + TAP_W'(1);
            if (idx_ff == last_tap) begin
               state_in = MAC_DRAIN;
            end
         end
         MAC_DRAIN: begin
            if (done) begin
               state_in = MAC_IDLE;
            end
         end
         default: begin
            state_in = MAC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MAC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_taps_ff <= TAPS_RESET;
         head_ff     <= '0;
      end else if (csr_wr_en) begin
         num_taps_ff <= csr_wr_data;
         head_ff     <= '0;
      end else if (start) begin
         head_ff <= head_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_vld_ff <= '0;
      end else if (start) begin
         line_vld_ff[head_eff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         delay_mem[head_eff] <= smp_item.sample;
      end
      if (issue) begin
         rd_data_ff <= delay_mem[k_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ok_ff <= line_vld_ff[k_ff];
         coef_ff  <= coef_rom(idx_ff);
      end
   end

   assign mul_a = rd_ok_ff ? $signed({1'b0, rd_data_ff}) : '0;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * coef_ff;
      if (start) begin
         acc_ff <= '0;
      end else if (s2_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   assign rnd_sum   = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(256);
   assign rnd_shift = rnd_sum >>> 9;

   always_comb begin
      if (rnd_shift > OUT_MAX) begin
         sat_value = RESULT_W'(OUT_MAX);
      end else if (rnd_shift < OUT_MIN) begin
         sat_value = RESULT_W'(OUT_MIN);
      end else begin
         sat_value = RESULT_W'(rnd_shift);
      end
   end

   assign res_item.vld            = done;
   assign res_item.filtered_value = sat_value;

endmodule

FILE: rtl/firadc_rsp_queue.sv
// ----------------------------------------------------------------------------
// firadc_rsp_queue
// Result side: two-entry queue that holds finished items until popped.
// ----------------------------------------------------------------------------
module firadc_rsp_queue (
   input  logic                                     clock,
   input  logic                                     reset,
   input  firadc_pkg::res_item_type                 res_item,
   output logic                                     res_room,
   output logic                                     empty,
   input  logic                                     pop,
   output logic signed [firadc_pkg::RESULT_W-1:0]   rsp_filtered_value
);
   import firadc_pkg::*;

   logic signed [RESULT_W-1:0] slot_ff [0:1];
   logic                       wr_ptr_ff;
   logic                       rd_ptr_ff;
   logic [1:0]                 count_ff;
   logic [1:0]                 count_in;
   logic                       do_pop;

   assign res_room           = (count_ff != 2'd2);
   assign empty              = (count_ff == 2'd0);
   assign do_pop             = pop && !empty;
   assign rsp_filtered_value = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (res_item.vld && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!res_item.vld && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (res_item.vld) begin
         slot_ff[wr_ptr_ff] <= res_item.filtered_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (res_item.vld) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

endmodule

FILE: rtl/fir_filter_adc_samples_core.sv
// ----------------------------------------------------------------------------
// fir_filter_adc_samples_core
// Direct-form low-pass FIR for unsigned 16-bit ADC samples.
// ----------------------------------------------------------------------------
// Each pushed sample enters a circular delay line and yields one filtered item
// in units of 1/256, rounded to nearest and saturated to 26 bits. One shared
// multiply-accumulate walks the taps one per cycle, 1 to 64 taps in use, and
// takes no new sample until the previous item has left the MAC;
// that loop sets the sustained rate. A four-entry input queue and a two-entry
// result queue let each side stall on its own. Writing num_taps restarts the
// ring at position zero without clearing the delay line; write it only while
// the block is idle.
// ----------------------------------------------------------------------------
module fir_filter_adc_samples_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     push,
   output logic                                     full,
   input  logic [firadc_pkg::SAMPLE_W-1:0]          req_sample,
   output logic                                     empty,
   input  logic                                     pop,
   output logic signed [firadc_pkg::RESULT_W-1:0]   rsp_filtered_value,
   input  logic                                     csr_wr_en,
   input  logic [firadc_pkg::TAPS_W-1:0]            csr_wr_data
);
   import firadc_pkg::*;

   smp_item_type smp_item;
   logic         smp_pop;
   res_item_type res_item;
   logic         res_room;

   firadc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_sample (req_sample),
      .smp_item   (smp_item),
      .smp_pop    (smp_pop)
   );

   firadc_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .smp_item    (smp_item),
      .smp_pop     (smp_pop),
      .res_room    (res_room),
      .res_item    (res_item)
   );

   firadc_rsp_queue u_rsp_queue (
      .clock              (clock),
      .reset              (reset),
      .res_item           (res_item),
      .res_room           (res_room),
      .empty              (empty),
      .pop                (pop),
      .rsp_filtered_value (rsp_filtered_value)
   );

endmodule

FILE: rtl/firadc_checker.sv
// ----------------------------------------------------------------------------
// firadc_checker
// Port-level checks of item accounting for the FIR core, bound to the top.
// ----------------------------------------------------------------------------
module firadc_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     push,
   input  logic                                     full,
   input  logic                                     empty,
   input  logic                                     pop,
   input  logic signed [firadc_pkg::RESULT_W-1:0]   rsp_filtered_value
);
   import firadc_pkg::*;

   logic [3:0] pending_ff;
   logic       in_acc;
   logic       out_acc;

   assign in_acc  = push && !full;
   assign out_acc = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 4'(in_acc) - 4'(out_acc);
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not empty after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !empty |-> pending_ff != 4'd0)
      else $error("result shown with no item outstanding");

   a_full_needs_items: assert property (@(posedge clock) disable iff (reset)
      full |-> pending_ff >= 4'd4)
      else $error("full raised with fewer than four items outstanding");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_filtered_value))
      else $error("waiting result changed or dropped");

endmodule

bind fir_filter_adc_samples_core firadc_checker u_firadc_checker (
   .clock              (clock),
   .reset              (reset),
   .push               (push),
   .full               (full),
   .empty              (empty),
   .pop                (pop),
   .rsp_filtered_value (rsp_filtered_value)
);
